@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the thermostat RTL. They expand to
// nothing when the code is built for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside of reset.
`define THL_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("thermostat assertion failed");

// Expression must never be true outside of reset.
`define THL_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("thermostat forbidden condition seen");

`else

`define THL_ASSERT(lbl, clk, rst_n, prop)
`define THL_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

@@ src/thl_pkg.sv @@
// ----------------------------------------------------------------------------
// Thermostat package
// Field widths, register indexes, status codes and shared structs.
// ----------------------------------------------------------------------------
package thl_pkg;

	localparam int TempW   = 18;
	localparam int TimeW   = 32;
	localparam int MinutesW = 11;
	localparam int IndexW  = 2;
	localparam int DataW   = 18;

	// Register indexes of the configuration port.
	localparam logic [IndexW-1:0] REG_TARGET     = 2'd0;
	localparam logic [IndexW-1:0] REG_HYSTERESIS = 2'd1;
	localparam logic [IndexW-1:0] REG_MIN_CHANGE = 2'd2;

	// Register reset values.
	localparam logic [TempW-1:0]    TARGET_RESET     = 18'd72000;
	localparam logic [TempW-1:0]    HYSTERESIS_RESET = 18'd2000;
	localparam logic [MinutesW-1:0] MIN_CHANGE_RESET = 11'd5;

	// Conversion constants: five times Fahrenheit in milli-F is raw*9 + 160000.
	localparam logic signed [22:0] F_OFFSET_X5 = 23'sd160000;
	localparam logic [21:0]        F_MAX_X5    = 22'd750000;
	// ceil(2^22 / 5); exact floor division by five for any value below 2^22.
	localparam logic [19:0]        RECIP5      = 20'd838861;
	localparam int                 RecipShift  = 22;

	localparam logic [5:0] SEC_PER_MIN = 6'd60;

	typedef enum logic [1:0] {
		STATUS_VALID = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_CRC   = 2'd2
	} status_t;

	typedef struct packed {
		logic [TempW-1:0]    target;
		logic [TempW-1:0]    hysteresis;
		logic [MinutesW-1:0] min_minutes;
	} cfg_t;

	typedef struct packed {
		status_t          status;
		logic [TempW-1:0] temp;
	} reading_t;

	typedef struct packed {
		logic ac_on;
		logic switched;
		logic blocked;
	} decision_t;

endpackage

@@ src/thl_sensor_if.sv @@
// ----------------------------------------------------------------------------
// Sensor channel
// Valid/ready channel carrying one sensor reading and the time of day.
// ----------------------------------------------------------------------------
interface thl_sensor_if
	import thl_pkg::*;
	;
	logic                    valid;
	logic                    ready;
	logic signed [TempW-1:0] raw_milli_c;
	logic                    sensor_crc_ok;
	logic [TimeW-1:0]        now_sec;

	modport source (output valid, raw_milli_c, sensor_crc_ok, now_sec, input ready);
	modport sink (input valid, raw_milli_c, sensor_crc_ok, now_sec, output ready);
endinterface

@@ src/thl_result_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the AC decision for one reading.
// ----------------------------------------------------------------------------
interface thl_result_if
	import thl_pkg::*;
	;
	logic             valid;
	logic             ready;
	logic             ac_on;
	logic             switched;
	logic             blocked;
	logic [1:0]       reading_status;
	logic [TempW-1:0] temp_milli_f;

	modport source (output valid, ac_on, switched, blocked, reading_status, temp_milli_f,
		input ready);
	modport sink (input valid, ac_on, switched, blocked, reading_status, temp_milli_f,
		output ready);
endinterface

@@ src/thl_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface thl_cfg_if
	import thl_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [IndexW-1:0] reg_index;
	logic [DataW-1:0]  wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

@@ src/thl_convert.sv @@
// ----------------------------------------------------------------------------
// Reading conversion
// Converts milli-Celsius to milli-Fahrenheit and classifies the reading.
// ----------------------------------------------------------------------------
module thl_convert
	import thl_pkg::*;
(
	input  logic signed [TempW-1:0] raw_milli_c,
	input  logic                    sensor_crc_ok,
	output reading_t                reading
);

	logic signed [22:0] raw_x;
	logic signed [22:0] num_x5;
	logic               out_of_range;
	logic [39:0]        prod;

	// Five times the Fahrenheit value: raw*9 + 160000, done as shift and add.
	assign raw_x  = {{(23-TempW){raw_milli_c[TempW-1]}}, raw_milli_c};
	assign num_x5 = (raw_x <<< 3) + raw_x + F_OFFSET_X5;

	// Range check on the exact value before any truncation.
	assign out_of_range = num_x5[22] || (num_x5[21:0] > F_MAX_X5);

	// Floor division by five through the reciprocal; the value is below 2^20 here.
	assign prod = {20'd0, num_x5[19:0]} * {20'd0, RECIP5};

	// Status and temperature; invalid readings report zero.
	always_comb begin
		if (!sensor_crc_ok) begin
			reading.status = STATUS_CRC;
			reading.temp   = '0;
		end else if (out_of_range) begin
			reading.status = STATUS_RANGE;
			reading.temp   = '0;
		end else begin
			reading.status = STATUS_VALID;
			reading.temp   = prod[RecipShift +: TempW];
		end
	end

endmodule

@@ src/thl_decide.sv @@
// ----------------------------------------------------------------------------
// AC decision
// Hysteresis request, minimum change time check and the AC state registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module thl_decide
	import thl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [TimeW-1:0] now_sec,
	input  reading_t         reading,
	input  cfg_t             cfg,
	output decision_t        decision
);

	logic             ac_state_q;
	logic [TimeW-1:0] last_change_q;
	logic [TempW:0]   on_level;
	logic [TempW:0]   off_level;
	logic             want;
	logic [TimeW-1:0] elapsed;
	logic [16:0]      min_sec;
	logic             time_ok;

	// Request on at or above target+hysteresis, off at or below target-hysteresis.
	assign on_level  = {1'b0, cfg.target} + {1'b0, cfg.hysteresis};
	assign off_level = {1'b0, reading.temp} + {1'b0, cfg.hysteresis};

	always_comb begin
		want = ac_state_q;
		if (on_level <= {1'b0, reading.temp}) begin
			want = 1'b1;
		end else if (off_level <= {1'b0, cfg.target}) begin
			want = 1'b0;
		end
	end

	// Wrapping elapsed time against the minimum change interval.
	assign elapsed = now_sec - last_change_q;
	assign min_sec = {6'd0, cfg.min_minutes} * {11'd0, SEC_PER_MIN};
	assign time_ok = elapsed >= {{(TimeW-17){1'b0}}, min_sec};

	always_comb begin
		decision.switched = 1'b0;
		decision.blocked  = 1'b0;
		if (reading.status == STATUS_VALID && want != ac_state_q) begin
			decision.switched = time_ok;
			decision.blocked  = !time_ok;
		end
		decision.ac_on = decision.switched ? want : ac_state_q;
	end

	// State moves only when the item leaves for the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac_state_q    <= 1'b0;
			last_change_q <= '0;
		end else if (en && decision.switched) begin
			ac_state_q    <= decision.ac_on;
			last_change_q <= now_sec;
		end
	end

	`THL_ASSERT(a_switch_updates, clk, arst_n,
		(en && decision.switched) |=> (last_change_q == $past(now_sec)
		&& ac_state_q != $past(ac_state_q)))
	`THL_ASSERT(a_hold_keeps_state, clk, arst_n,
		(en && !decision.switched) |=> ($stable(ac_state_q) && $stable(last_change_q)))
	`THL_ASSERT_NEVER(a_switch_and_block, clk, arst_n,
		decision.switched && decision.blocked)

endmodule

@@ src/thermostat_hysteresis_lockout_core.sv @@
// ----------------------------------------------------------------------------
// Thermostat with hysteresis and lockout
// Bang-bang AC control from Celsius readings with a minimum change interval.
//
//   channel  | dir  | word
//   ---------+------+----------------------------------------------------
//   sensor   | in   | raw_milli_c, sensor_crc_ok, now_sec
//   result   | out  | ac_on, switched, blocked, reading_status, temp_milli_f
//   cfg      | in   | reg_index, wdata (always ready)
//
// One word per cycle while the result channel is ready; a word passes the
// input register and then the result register, with conversion and decision
// logic between them. The AC state updates as a word enters the result
// register, so the next word sees it at once. A stalled result holds the
// result register, and the input register then stops once it is full.
// Reset loads the register defaults and turns the AC off; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module thermostat_hysteresis_lockout_core
	import thl_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	thl_sensor_if.sink   sensor,
	thl_result_if.source result,
	thl_cfg_if.sink      cfg
);

	cfg_t                    cfg_q;
	logic                    v_s1;
	logic signed [TempW-1:0] raw_s1;
	logic                    crc_s1;
	logic [TimeW-1:0]        now_s1;
	logic                    v_s2;
	decision_t               dec_s2;
	status_t                 status_s2;
	logic [TempW-1:0]        temp_s2;
	logic                    adv;
	logic                    in_acc;
	reading_t                reading;
	decision_t               decision;

	// Configuration registers; unknown indexes are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target      <= TARGET_RESET;
			cfg_q.hysteresis  <= HYSTERESIS_RESET;
			cfg_q.min_minutes <= MIN_CHANGE_RESET;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				REG_TARGET:     cfg_q.target      <= cfg.wdata[TempW-1:0];
				REG_HYSTERESIS: cfg_q.hysteresis  <= cfg.wdata[TempW-1:0];
				REG_MIN_CHANGE: cfg_q.min_minutes <= cfg.wdata[MinutesW-1:0];
				default: ;
			endcase
		end
	end

	// Stage handshakes.
	assign adv          = v_s1 && (!v_s2 || result.ready);
	assign sensor.ready = !v_s1 || adv;
	assign in_acc       = sensor.valid && sensor.ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (sensor.ready) begin
			v_s1 <= sensor.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			raw_s1 <= sensor.raw_milli_c;
			crc_s1 <= sensor.sensor_crc_ok;
			now_s1 <= sensor.now_sec;
		end
	end

	// Conversion and decision between the two registers.
	thl_convert u_convert (
		.raw_milli_c   (raw_s1),
		.sensor_crc_ok (crc_s1),
		.reading       (reading)
	);

	thl_decide u_decide (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.now_sec  (now_s1),
		.reading  (reading),
		.cfg      (cfg_q),
		.decision (decision)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!v_s2 || result.ready) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dec_s2    <= decision;
			status_s2 <= reading.status;
			temp_s2   <= reading.temp;
		end
	end

	assign result.valid          = v_s2;
	assign result.ac_on          = dec_s2.ac_on;
	assign result.switched       = dec_s2.switched;
	assign result.blocked        = dec_s2.blocked;
	assign result.reading_status = status_s2;
	assign result.temp_milli_f   = temp_s2;

	`THL_ASSERT(a_invalid_is_quiet, clk, arst_n,
		(v_s2 && status_s2 != STATUS_VALID) |-> (temp_s2 == '0 && !dec_s2.switched
		&& !dec_s2.blocked))
	`THL_ASSERT(a_full_stall_blocks, clk, arst_n,
		(v_s1 && v_s2 && !result.ready) |-> !sensor.ready)
	`THL_ASSERT(a_accept_fills_s1, clk, arst_n,
		in_acc |=> v_s1)

endmodule

@@ dv/thermostat_decision_checker.sv @@
// ----------------------------------------------------------------------------
// Thermostat decision checker
// Watches the sensor, result and configuration channels of the thermostat
// core. Each accepted sensor word is run through a predictor of the AC
// decision, which keeps its own copy of the registers and the AC state. Each
// accepted result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module thermostat_decision_checker
	import thl_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	thl_sensor_if sensor,
	thl_result_if result,
	thl_cfg_if    cfg,
	output int    mismatches,
	output int    outstanding,
	output int    switch_total,
	output int    block_total
);
	timeunit 1ns;
	timeprecision 1ps;

	// Five times the Fahrenheit value is raw*9 plus the offset.
	localparam longint C_TO_F_X5 = 9;
	localparam longint X5_DIVISOR = 5;
	localparam int ReportLimit = 10;

	typedef struct packed {
		logic             ac_on;
		logic             switched;
		logic             blocked;
		status_t          status;
		logic [TempW-1:0] temp;
	} decision_word_t;

	cfg_t             reg_shadow;
	logic             ac_now;
	logic [TimeW-1:0] last_change;
	decision_word_t   expected_decisions[$];
	int               mismatch_count;
	int               result_index;
	int               switch_count;
	int               block_count;

	// Works out the result word for one sensor word and advances the AC state.
	function automatic decision_word_t predict_decision(
		input logic signed [TempW-1:0] raw,
		input logic                    crc_ok,
		input logic [TimeW-1:0]        now
	);
		decision_word_t   word;
		longint           scaled;
		longint           temp_f;
		longint           upper;
		longint           lower;
		logic             want;
		logic [TimeW-1:0] elapsed;
		logic [TimeW-1:0] hold_sec;
		word = '0;
		if (!crc_ok) begin
			word.status = STATUS_CRC;
		end else begin
			scaled = longint'(raw) * C_TO_F_X5 + longint'(F_OFFSET_X5);
			if (scaled < 0 || scaled > longint'(F_MAX_X5)) begin
				word.status = STATUS_RANGE;
			end else begin
				temp_f = scaled / X5_DIVISOR;
				upper = longint'(reg_shadow.target) + longint'(reg_shadow.hysteresis);
				lower = longint'(reg_shadow.target) - longint'(reg_shadow.hysteresis);
				word.status = STATUS_VALID;
				word.temp = temp_f[TempW-1:0];
				want = ac_now;
				if (upper <= temp_f)
					want = 1'b1;
				else if (temp_f <= lower)
					want = 1'b0;
				if (want != ac_now) begin
					// The modulo difference makes a backward clock look like a long wait.
					elapsed = now - last_change;
					hold_sec = TimeW'(reg_shadow.min_minutes) * TimeW'(SEC_PER_MIN);
					if (elapsed >= hold_sec) begin
						ac_now = want;
						last_change = now;
						word.switched = 1'b1;
						switch_count++;
					end else begin
						word.blocked = 1'b1;
						block_count++;
					end
				end
			end
		end
		word.ac_on = ac_now;
		return word;
	endfunction

	// Compare results first, then apply register writes, then predict.
	always @(posedge clk or negedge arst_n) begin
		decision_word_t want_word;
		decision_word_t got_word;
		if (!arst_n) begin
			reg_shadow.target = TARGET_RESET;
			reg_shadow.hysteresis = HYSTERESIS_RESET;
			reg_shadow.min_minutes = MIN_CHANGE_RESET;
			ac_now = 1'b0;
			last_change = '0;
			expected_decisions.delete();
			mismatch_count = 0;
			result_index = 0;
			switch_count = 0;
			block_count = 0;
		end else begin
			if (result.valid && result.ready) begin
				got_word.ac_on = result.ac_on;
				got_word.switched = result.switched;
				got_word.blocked = result.blocked;
				got_word.status = status_t'(result.reading_status);
				got_word.temp = result.temp_milli_f;
				if (expected_decisions.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= ReportLimit)
						$display("result %0d arrived with no reading outstanding: ac_on=%0b switched=%0b blocked=%0b status=%0d temp=%0d",
							result_index, got_word.ac_on, got_word.switched,
							got_word.blocked, got_word.status, got_word.temp);
				end else begin
					want_word = expected_decisions.pop_front();
					if (got_word !== want_word) begin
						mismatch_count++;
						if (mismatch_count <= ReportLimit)
							$display("result %0d: expected ac_on=%0b switched=%0b blocked=%0b status=%0d temp=%0d, got ac_on=%0b switched=%0b blocked=%0b status=%0d temp=%0d",
								result_index, want_word.ac_on, want_word.switched,
								want_word.blocked, want_word.status, want_word.temp,
								got_word.ac_on, got_word.switched, got_word.blocked,
								got_word.status, got_word.temp);
					end
				end
				result_index++;
			end

			// Writes to an unused index leave the registers alone.
			if (cfg.valid && cfg.ready) begin
				case (cfg.reg_index)
					REG_TARGET: reg_shadow.target = cfg.wdata;
					REG_HYSTERESIS: reg_shadow.hysteresis = cfg.wdata;
					REG_MIN_CHANGE: reg_shadow.min_minutes = cfg.wdata[MinutesW-1:0];
					default: ;
				endcase
			end

			if (sensor.valid && sensor.ready)
				expected_decisions.push_back(predict_decision(sensor.raw_milli_c,
					sensor.sensor_crc_ok, sensor.now_sec));
		end
		mismatches <= mismatch_count;
		outstanding <= expected_decisions.size();
		switch_total <= switch_count;
		block_total <= block_count;
	end

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Thermostat core testbench
// Drives sensor words and register writes into the thermostat core with
// random gaps on both channels and one long result stall. A directed part
// covers range edges, CRC failures, lockout and clock wrap; random phases
// follow under several register settings, extremes among them. The checker
// predicts and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench
	import thl_pkg::*;
	;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [IndexW-1:0] REG_UNUSED = 2'd3;
	localparam int  PhaseWords = 175;
	localparam longint MaxTempReg = 262143;
	// Raw readings whose Fahrenheit value stays inside 0 to 150 F.
	localparam longint RawLowValid = -17777;
	localparam longint RawHighValid = 65555;

	logic clk;
	logic arst_n;

	thl_sensor_if sensor_ch();
	thl_result_if result_ch();
	thl_cfg_if    cfg_ch();

	int mismatches;
	int outstanding;
	int switch_total;
	int block_total;

	bit               tx_quiet;
	bit               rx_quiet;
	int               hold_off_cycles;
	int               words_sent;
	int               reg_writes;
	logic [TimeW-1:0] wall_sec;
	longint           tb_target;
	longint           tb_hyst;
	logic [TimeW-1:0] tb_hold_sec;

	thermostat_hysteresis_lockout_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.sensor (sensor_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	thermostat_decision_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.sensor       (sensor_ch),
		.result       (result_ch),
		.cfg          (cfg_ch),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.switch_total (switch_total),
		.block_total  (block_total)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap(input bit quiet);
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Reading near one of the switching points, or now and then anything at all.
	function automatic logic signed [TempW-1:0] pick_raw();
		int     roll;
		longint f_val;
		longint c_val;
		roll = $urandom_range(0, 99);
		if (roll < 12)
			return TempW'($urandom);
		f_val = (roll < 56) ? tb_target + tb_hyst : tb_target - tb_hyst;
		if (roll % 3 == 0)
			f_val += longint'($urandom_range(0, 6000)) - 3000;
		else
			f_val += longint'($urandom_range(0, 40)) - 20;
		c_val = ((f_val - 32000) * 5) / 9;
		if (c_val < RawLowValid)
			c_val = RawLowValid;
		if (c_val > RawHighValid)
			c_val = RawHighValid;
		return c_val[TempW-1:0];
	endfunction

	// Advance the wall clock, often to just around the lockout time.
	function automatic logic [TimeW-1:0] next_time(input logic [TimeW-1:0] now);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return $urandom;
		if (roll < 50)
			return now + tb_hold_sec + TimeW'($urandom_range(0, 4)) - TimeW'(2);
		return now + TimeW'($urandom_range(0, tb_hold_sec / 2 + 3));
	endfunction

	task automatic send_reading(
		input logic signed [TempW-1:0] raw,
		input logic                    crc_ok,
		input logic [TimeW-1:0]        now
	);
		int gap;
		gap = pick_gap(tx_quiet);
		if (gap > 0) begin
			sensor_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sensor_ch.valid <= 1'b1;
		sensor_ch.raw_milli_c <= raw;
		sensor_ch.sensor_crc_ok <= crc_ok;
		sensor_ch.now_sec <= now;
		do @(posedge clk); while (!sensor_ch.ready);
		words_sent++;
	endtask

	task automatic write_reg(input logic [IndexW-1:0] idx, input logic [DataW-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wdata <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		reg_writes++;
		@(posedge clk);
	endtask

	// Ends the current burst and waits until every result has come back.
	task automatic drain();
		sensor_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic load_settings(input longint target, input longint hyst, input int minutes);
		write_reg(REG_TARGET, DataW'(target));
		write_reg(REG_HYSTERESIS, DataW'(hyst));
		write_reg(REG_MIN_CHANGE, DataW'(minutes));
		tb_target = target;
		tb_hyst = hyst;
		tb_hold_sec = TimeW'(minutes) * TimeW'(SEC_PER_MIN);
	endtask

	task automatic run_phase(input longint target, input longint hyst, input int minutes,
			input bit quiet_tx, input bit quiet_rx, input int stall);
		int n;
		drain();
		load_settings(target, hyst, minutes);
		tx_quiet = quiet_tx;
		rx_quiet = quiet_rx;
		hold_off_cycles = stall;
		for (n = 0; n < PhaseWords; n++) begin
			wall_sec = next_time(wall_sec);
			send_reading(pick_raw(), $urandom_range(0, 99) < 90, wall_sec);
		end
	endtask

	// Result side: random stalls, plus one long hold-off when asked for.
	initial begin
		int gap;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_off_cycles > 0) begin
				result_ch.ready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end
			result_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			gap = pick_gap(rx_quiet);
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		sensor_ch.valid <= 1'b0;
		sensor_ch.raw_milli_c <= '0;
		sensor_ch.sensor_crc_ok <= 1'b0;
		sensor_ch.now_sec <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.reg_index <= REG_TARGET;
		cfg_ch.wdata <= '0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		hold_off_cycles = 0;
		words_sent = 0;
		reg_writes = 0;
		wall_sec = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: range edges and CRC failures first.
		send_reading(-18'sd131072, 1'b1, 32'd0);
		send_reading(18'sd131071, 1'b1, 32'd1);
		send_reading(-18'sd55000, 1'b1, 32'd1);
		send_reading(18'sd125000, 1'b1, 32'd1);
		send_reading(18'sd65555, 1'b0, 32'd1);
		send_reading(-18'sd131072, 1'b0, 32'hFFFF_FFFF);
		send_reading(-18'sd17777, 1'b1, 32'd2);
		send_reading(-18'sd17778, 1'b1, 32'd2);
		send_reading(18'sd65556, 1'b1, 32'd2);

		// Lockout of five minutes: held back, then made once 300 s have passed.
		send_reading(18'sd65555, 1'b1, 32'd100);
		send_reading(18'sd65555, 1'b1, 32'd299);
		send_reading(18'sd65555, 1'b1, 32'd300);
		send_reading(18'sd23333, 1'b1, 32'd301);
		send_reading(18'sd0, 1'b1, 32'd599);
		send_reading(18'sd0, 1'b1, 32'd600);

		// A clock that runs backwards counts as a long wait.
		send_reading(18'sd65555, 1'b1, 32'd5);
		send_reading(18'sd20000, 1'b1, 32'hFFFF_FFFF);

		// Readings that land exactly on both switching points, no lockout.
		drain();
		load_settings(50000, 18000, 0);
		send_reading(18'sd20000, 1'b1, 32'd0);
		send_reading(18'sd0, 1'b1, 32'd0);
		send_reading(18'sd10000, 1'b1, 32'd0);

		// Zero hysteresis: on at the target itself, off just below it.
		drain();
		write_reg(REG_HYSTERESIS, '0);
		write_reg(REG_UNUSED, DataW'($urandom));
		send_reading(18'sd10000, 1'b1, 32'd7);
		send_reading(18'sd9999, 1'b1, 32'd7);

		// Widest registers and the longest lockout.
		drain();
		load_settings(MaxTempReg, MaxTempReg, 2047);
		send_reading(-18'sd17777, 1'b1, 32'd8);
		send_reading(18'sd65555, 1'b1, 32'h8000_0000);

		// Random phases under a spread of settings.
		run_phase($urandom_range(40000, 110000), $urandom_range(0, 6000),
			$urandom_range(0, 3), 1'b0, 1'b0, 0);
		run_phase($urandom_range(40000, 110000), $urandom_range(0, 6000),
			$urandom_range(1, 10), 1'b1, 1'b1, 0);
		run_phase($urandom_range(40000, 110000), $urandom_range(0, 6000),
			$urandom_range(0, 5), 1'b1, 1'b0, 200);
		run_phase(0, 0, 0, 1'b0, 1'b0, 0);
		run_phase(150000, 150000, 1440, 1'b0, 1'b0, 0);
		drain();
		write_reg(REG_UNUSED, DataW'($urandom));
		run_phase(MaxTempReg, $urandom_range(0, MaxTempReg), 2047, 1'b0, 1'b0, 0);

		drain();
		repeat (16) @(posedge clk);
		$display("Sent %0d sensor words across %0d register writes, some at the extremes.",
			words_sent, reg_writes);
		$display("Predicted %0d AC changes and %0d changes held back by the lockout.",
			switch_total, block_total);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+src
src/thl_pkg.sv
src/thl_sensor_if.sv
src/thl_result_if.sv
src/thl_cfg_if.sv
src/thl_convert.sv
src/thl_decide.sv
src/thermostat_hysteresis_lockout_core.sv
dv/thermostat_decision_checker.sv
dv/testbench.sv
